/* sv/ggc_pkg.sv */
// ---------------------------------------------------------------------------
// ggc_pkg
// Shared sizes, field widths and request/status/result types of the greedy
// graph colouring core.
// ---------------------------------------------------------------------------
`default_nettype none

package ggc_pkg;

    // graph and palette sizes
    localparam int NODE_COUNT = 1024;
    localparam int MAX_COLORS = 64;

    // derived field widths
    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int COLOR_W = $clog2(MAX_COLORS);
    localparam int COUNT_W = $clog2(MAX_COLORS + 1);

    // generation tag kept beside each stored colour
    localparam int EPOCH_W    = 4;
    localparam int WORD_W     = EPOCH_W + COLOR_W;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // input item kinds carried in s_tuser
    localparam logic ACT_NEIGHBOR = 1'b0;
    localparam logic ACT_CLEAR    = 1'b1;

    // requests from the colouring pipeline to the colour store
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [COLOR_W-1:0] wr_color;
        logic              clear;
    } ggc_mem_req_t;

    // status back from the colour store
    typedef struct packed {
        logic               busy;
        logic               epoch_full;
        logic               rd_colored;
        logic [COLOR_W-1:0] rd_color;
    } ggc_mem_stat_t;

    // one result waiting in the output queue
    typedef struct packed {
        logic               no_free_color;
        logic [COUNT_W-1:0] colors_used;
        logic [COLOR_W-1:0] assigned_color;
        logic [NODE_W-1:0]  colored_node;
    } ggc_result_t;

endpackage

`default_nettype wire

/* sv/ggc_color_store.sv */
// ---------------------------------------------------------------------------
// ggc_color_store
// Node colour memory with a generation tag per entry. A node counts as
// coloured when its tag equals the current generation. A clear bumps the
// generation; when the tag space runs out a sweep rewrites every entry.
// ---------------------------------------------------------------------------
`default_nettype none

module ggc_color_store (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire ggc_pkg::ggc_mem_req_t req,
    output ggc_pkg::ggc_mem_stat_t stat
);

    logic [ggc_pkg::WORD_W-1:0]  mem [ggc_pkg::NODE_COUNT];

    logic [ggc_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic                        sweep_reg, sweep_next;
    logic [ggc_pkg::NODE_W-1:0]  sweep_addr_reg, sweep_addr_next;

    logic [ggc_pkg::WORD_W-1:0]  rd_word_reg;
    logic                        fwd_hit_reg;
    logic [ggc_pkg::WORD_W-1:0]  fwd_word_reg;

    logic                        mem_we;
    logic [ggc_pkg::NODE_W-1:0]  mem_waddr;
    logic [ggc_pkg::WORD_W-1:0]  mem_wdata;
    logic [ggc_pkg::WORD_W-1:0]  word;

    // generation and sweep control
    always_comb begin
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        if (sweep_reg) begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == ggc_pkg::NODE_W'(ggc_pkg::NODE_COUNT - 1)) begin
                sweep_next = 1'b0;
            end
        end else if (req.clear) begin
            if (epoch_reg == ggc_pkg::EPOCH_LAST) begin
                epoch_next      = ggc_pkg::EPOCH_FIRST;
                sweep_next      = 1'b1;
                sweep_addr_next = '0;
            end else begin
                epoch_next = epoch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg      <= ggc_pkg::EPOCH_FIRST;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end else begin
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    // write port: sweep has priority, nothing else writes while it runs
    always_comb begin
        if (sweep_reg) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = {ggc_pkg::EPOCH_STALE, {ggc_pkg::COLOR_W{1'b0}}};
        end else begin
            mem_we    = req.wr_en;
            mem_waddr = req.wr_addr;
            mem_wdata = {epoch_reg, req.wr_color};
        end
    end

    // memory with registered read, read-before-write
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (req.rd_en) begin
            rd_word_reg <= mem[req.rd_addr];
        end
    end

    // forward a write that lands on the entry read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (req.rd_en) begin
            fwd_hit_reg <= mem_we && (mem_waddr == req.rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            fwd_word_reg <= mem_wdata;
        end
    end

    assign word            = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
    assign stat.rd_colored = (word[ggc_pkg::WORD_W-1 -: ggc_pkg::EPOCH_W] == epoch_reg);
    assign stat.rd_color   = word[ggc_pkg::COLOR_W-1:0];
    assign stat.busy       = sweep_reg;
    assign stat.epoch_full = (epoch_reg == ggc_pkg::EPOCH_LAST);

    // no pipeline access while the sweep owns the memory
    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_reg |-> !req.wr_en && !req.rd_en)
        else $error("colour store accessed during sweep");

    // generation never takes the stale value
    a_epoch_live: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != ggc_pkg::EPOCH_STALE)
        else $error("generation reached stale tag");

    // a clear at the last generation starts a sweep
    a_wrap_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (!sweep_reg && req.clear && epoch_reg == ggc_pkg::EPOCH_LAST) |=> sweep_reg)
        else $error("generation wrapped without sweep");

endmodule

`default_nettype wire

/* sv/greedy_graph_coloring_core.sv */
// ---------------------------------------------------------------------------
// greedy_graph_coloring_core
// First-fit greedy graph colouring over a stream of neighbour items.
// ---------------------------------------------------------------------------
//  channel  | direction | contents
//  s_       | in        | tdata: node_id[9:0] neighbor_id[19:10] has_neighbor[20]
//           |           | tuser: action, tlast: last_neighbor
//  m_       | out       | tdata: colored_node[9:0] assigned_color[15:10]
//           |           |        colors_used[22:16] no_free_color[23]
//  cfg_     | in        | data: color_limit[6:0]
//
// One item per cycle while s_tready is high; a result enters the output queue
// from the second-stage registers of its last item. The colour memory sets the
// pace: one read per item and one write per coloured node, on its separate
// read and write ports in the same cycle.
// After reset a sweep over all 1024 entries initialises the colour memory and the
// input is held off; every fifteenth clear item starts the same sweep.
// A two-entry output queue absorbs m_tready stalls; apart from the sweep,
// s_tready drops only when the queue could overflow or a sweep is due.
// ---------------------------------------------------------------------------
`default_nettype none

module greedy_graph_coloring_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // node_id[9:0], neighbor_id[19:10], has_neighbor[20], zero fill
    input  wire  [ggc_pkg::S_TDATA_W-1:0]    s_tdata,
    // action[0]
    input  wire                              s_tuser,
    input  wire                              s_tlast,
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // colored_node[9:0], assigned_color[15:10], colors_used[22:16],
    // no_free_color[23]
    output logic [ggc_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [ggc_pkg::COUNT_W-1:0]      cfg_data
);

    ggc_pkg::ggc_mem_req_t  mreq;
    ggc_pkg::ggc_mem_stat_t mstat;

    logic                         s_fire;
    logic [ggc_pkg::COUNT_W-1:0]  limit_reg;

    // second stage registers
    logic                         v1_reg;
    logic                         clear1_reg;
    logic [ggc_pkg::NODE_W-1:0]   node1_reg;
    logic                         has1_reg;
    logic                         last1_reg;

    logic [ggc_pkg::MAX_COLORS-1:0] mask_reg, mask_next;
    logic [ggc_pkg::COUNT_W-1:0]    high_reg, high_next;

    logic [ggc_pkg::COUNT_W-1:0]    limit_eff;
    logic [ggc_pkg::MAX_COLORS-1:0] limit_mask;
    logic [ggc_pkg::MAX_COLORS-1:0] nb_bit;
    logic [ggc_pkg::MAX_COLORS-1:0] mask_all;
    logic [ggc_pkg::MAX_COLORS-1:0] cand;
    logic                           found;
    logic [ggc_pkg::COLOR_W-1:0]    chosen;
    logic [ggc_pkg::COUNT_W-1:0]    chosen_p1;
    logic                           push;
    ggc_pkg::ggc_result_t           res;

    // output queue
    ggc_pkg::ggc_result_t q_reg [2];
    logic                 wp_reg, rp_reg;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 pop;
    logic [1:0]           cnt_after_pop;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ggc_pkg::COUNT_W'(ggc_pkg::MAX_COLORS);
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // input acceptance: room for every result in flight, no sweep pending
    assign pop           = m_tvalid && m_tready;
    assign cnt_after_pop = cnt_reg - {1'b0, pop};
    assign s_tready      = !mstat.busy
                           && !(v1_reg && clear1_reg && mstat.epoch_full)
                           && ((cnt_after_pop + {1'b0, v1_reg}) <= 2'd1);
    assign s_fire        = s_tvalid && s_tready;

    // first stage: read the neighbour's colour
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            clear1_reg <= (s_tuser == ggc_pkg::ACT_CLEAR);
            node1_reg  <= s_tdata[ggc_pkg::NODE_W-1:0];
            has1_reg   <= s_tdata[2*ggc_pkg::NODE_W];
            last1_reg  <= s_tlast;
        end
    end

    // effective search limit and candidate window
    always_comb begin
        limit_eff = (limit_reg > ggc_pkg::COUNT_W'(ggc_pkg::MAX_COLORS))
                    ? ggc_pkg::COUNT_W'(ggc_pkg::MAX_COLORS) : limit_reg;
        for (int i = 0; i < ggc_pkg::MAX_COLORS; i++) begin
            limit_mask[i] = (ggc_pkg::COUNT_W'(i) < limit_eff);
            nb_bit[i]     = has1_reg && mstat.rd_colored
                            && (mstat.rd_color == ggc_pkg::COLOR_W'(i));
        end
    end

    // second stage: mark forbidden colour and pick the lowest free one
    assign mask_all = mask_reg | nb_bit;
    assign cand     = ~mask_all & limit_mask;
    assign found    = |cand;

    always_comb begin
        chosen = '0;
        for (int i = ggc_pkg::MAX_COLORS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                chosen = ggc_pkg::COLOR_W'(i);
            end
        end
    end

    assign chosen_p1 = ggc_pkg::COUNT_W'(chosen) + 1'b1;
    assign push      = v1_reg && !clear1_reg && last1_reg;

    // mask and highest-colour update
    always_comb begin
        mask_next = mask_reg;
        high_next = high_reg;
        if (v1_reg) begin
            if (clear1_reg) begin
                mask_next = '0;
                high_next = '0;
            end else if (last1_reg) begin
                mask_next = '0;
                if (found && (chosen_p1 > high_reg)) begin
                    high_next = chosen_p1;
                end
            end else begin
                mask_next = mask_all;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            high_reg <= '0;
        end else begin
            mask_reg <= mask_next;
            high_reg <= high_next;
        end
    end

    // colour store requests
    always_comb begin
        mreq.rd_en    = s_fire;
        mreq.rd_addr  = s_tdata[2*ggc_pkg::NODE_W-1:ggc_pkg::NODE_W];
        mreq.wr_en    = push && found;
        mreq.wr_addr  = node1_reg;
        mreq.wr_color = chosen;
        mreq.clear    = v1_reg && clear1_reg;
    end

    ggc_color_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .stat    (mstat)
    );

    // result of this transaction
    always_comb begin
        res.colored_node   = node1_reg;
        res.assigned_color = found ? chosen : '0;
        res.colors_used    = high_next;
        res.no_free_color  = !found;
    end

    // two-entry output queue
    assign cnt_next = cnt_after_pop + {1'b0, push};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= res;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = ggc_pkg::M_TDATA_W'(q_reg[rp_reg]);

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("output queue overflow");

    // input is held off while the memory is swept
    a_hold_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        mstat.busy |-> !s_tready)
        else $error("input accepted during sweep");

    // a clear empties the colour count
    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && clear1_reg) |=> (high_reg == '0) && (mask_reg == '0))
        else $error("clear left colour state behind");

    // a node without a free colour reports colour zero
    a_fault_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !found) |-> (res.assigned_color == '0))
        else $error("fault result carries a colour");

endmodule

`default_nettype wire
